[rtl/core/akph_pkg.sv]
// Shared types, codes and helper functions for the aligned k-mer pair histogram.
`default_nettype none

package akph_pkg;

    localparam int unsigned RADIX            = 5;
    localparam int unsigned WINDOW_LIMIT     = 4;
    localparam int unsigned CODE_BITS        = 3;
    localparam logic [7:0]  GAP_CHAR         = 8'h2D;
    localparam logic [2:0]  CODE_GAP         = 3'd4;
    localparam logic [1:0]  WINDOW_LEN_RESET = 2'd3;

    typedef enum logic [1:0] {
        CMD_COLUMN = 2'd0,
        CMD_END    = 2'd1,
        CMD_READ   = 2'd2
    } cmd_t;

    function automatic int unsigned pow5(input int unsigned n);
        int unsigned p;
        p = 1;
        for (int unsigned i = 0; i < WINDOW_LIMIT; i++) begin
            if (i < n) begin
                p = p * RADIX;
            end
        end
        return p;
    endfunction

    function automatic logic [CODE_BITS-1:0] char_code(input logic [7:0] ch);
        logic [CODE_BITS-1:0] code;
        case (ch)
            GAP_CHAR:     code = CODE_GAP;
            8'h43, 8'h63: code = 3'd1;
            8'h47, 8'h67: code = 3'd2;
            8'h54, 8'h74: code = 3'd3;
            default:      code = 3'd0;
        endcase
        return code;
    endfunction

endpackage

`default_nettype wire

[rtl/core/aligned_kmer_pair_histogram.sv]
// Aligned k-mer pair histogram: window tracking, count memories and read-modify-write control.
// A column that completes a window reads its counts at acceptance, then updates the pair and
// row sum in S_UPD, then updates the column sum in S_COL while the next transaction is taken.
// Other columns, end and unused commands go to S_IDLE; a read registers m_count in S_RD.
// Sustained rate is set by the single write port of the marginal-sum memory.
// After reset a clearing pass zeroes all pair-count and marginal-sum entries;
// s_ready stays low meanwhile, configuration writes are taken at any time.
`default_nettype none

module aligned_kmer_pair_histogram #(
    parameter int MAX_WINDOW = 3,
    parameter int COUNT_BITS = 32
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        cfg_valid,
    output logic       cfg_ready,
    input  wire [1:0]  cfg_window_len,
    input  wire        s_valid,
    output logic       s_ready,
    input  wire [1:0]  s_cmd,
    input  wire [7:0]  s_target_char,
    input  wire [7:0]  s_query_char,
    input  wire [6:0]  s_row_index,
    input  wire [6:0]  s_col_index,
    output logic       m_valid,
    input  wire        m_ready,
    output logic [31:0] m_count
);

    import akph_pkg::*;

    localparam int DIM        = pow5(MAX_WINDOW);
    localparam int DIGIT_BITS = $clog2(DIM);
    localparam int PAIR_DEPTH = DIM * DIM;
    localparam int PAIR_AW    = $clog2(PAIR_DEPTH);
    localparam int MARG_DEPTH = 2 * DIM;
    localparam int MARG_AW    = $clog2(MARG_DEPTH);
    localparam int EXT_BITS   = (COUNT_BITS > 32) ? COUNT_BITS : 32;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_UPD,
        S_COL,
        S_RD
    } state_t;

    typedef enum logic [2:0] {
        RD_PAIR,
        RD_ROW,
        RD_COL,
        RD_TOTAL,
        RD_ZERO
    } rd_kind_t;

    function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
        return (&v) ? v : v + COUNT_BITS'(1);
    endfunction

    state_t                  state_reg, state_next;
    rd_kind_t                rd_kind_reg, rd_kind_next;
    logic [PAIR_AW-1:0]      clr_reg, clr_next;
    logic [COUNT_BITS-1:0]   total_reg, total_next;
    logic                    fwd_reg, fwd_next;
    logic [COUNT_BITS-1:0]   fwd_data_reg, fwd_data_next;
    logic                    m_valid_reg, m_valid_next;
    logic [31:0]             m_count_reg, m_count_next;

    logic                    s_accept;
    logic                    col_acc;
    logic                    end_acc;
    logic                    rd_acc;
    logic                    r_lt, r_eq, c_lt, c_eq;
    rd_kind_t                rd_kind_in;

    logic                    win_hit;
    logic [DIGIT_BITS-1:0]   win_target_next;
    logic [DIGIT_BITS-1:0]   win_query_next;
    logic [DIGIT_BITS-1:0]   win_target;
    logic [DIGIT_BITS-1:0]   win_query;

    logic                    pair_we, pair_re;
    logic [PAIR_AW-1:0]      pair_waddr, pair_raddr;
    logic [COUNT_BITS-1:0]   pair_wdata, pair_rdata;
    logic                    marg_we, marg_re;
    logic [MARG_AW-1:0]      marg_waddr, marg_raddr;
    logic [COUNT_BITS-1:0]   marg_wdata, marg_rdata;
    logic [COUNT_BITS-1:0]   marg_data;

    logic [COUNT_BITS-1:0]   sel_val;
    logic [EXT_BITS-1:0]     sel_ext;

    assign cfg_ready = 1'b1;

    assign s_ready = (state_reg == S_IDLE || state_reg == S_COL) &&
                     (s_cmd != CMD_READ || !m_valid_reg || m_ready);
    assign s_accept = s_valid && s_ready;
    assign col_acc  = s_accept && (s_cmd == CMD_COLUMN);
    assign end_acc  = s_accept && (s_cmd == CMD_END);
    assign rd_acc   = s_accept && (s_cmd == CMD_READ);

    akph_window #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_valid && cfg_ready),
        .cfg_len     (cfg_window_len),
        .col_en      (col_acc),
        .end_en      (end_acc),
        .target_char (s_target_char),
        .query_char  (s_query_char),
        .hit         (win_hit),
        .target_next (win_target_next),
        .query_next  (win_query_next),
        .target      (win_target),
        .query       (win_query)
    );

    akph_ram #(
        .DEPTH (PAIR_DEPTH),
        .WIDTH (COUNT_BITS)
    ) u_pair_ram (
        .aclk    (aclk),
        .wr_en   (pair_we),
        .wr_addr (pair_waddr),
        .wr_data (pair_wdata),
        .rd_en   (pair_re),
        .rd_addr (pair_raddr),
        .rd_data (pair_rdata)
    );

    akph_ram #(
        .DEPTH (MARG_DEPTH),
        .WIDTH (COUNT_BITS)
    ) u_marg_ram (
        .aclk    (aclk),
        .wr_en   (marg_we),
        .wr_addr (marg_waddr),
        .wr_data (marg_wdata),
        .rd_en   (marg_re),
        .rd_addr (marg_raddr),
        .rd_data (marg_rdata)
    );

    assign marg_data = fwd_reg ? fwd_data_reg : marg_rdata;

    always_comb begin
        r_lt = int'(s_row_index) < DIM;
        r_eq = int'(s_row_index) == DIM;
        c_lt = int'(s_col_index) < DIM;
        c_eq = int'(s_col_index) == DIM;
        if (r_lt && c_lt) begin
            rd_kind_in = RD_PAIR;
        end else if (r_lt && c_eq) begin
            rd_kind_in = RD_ROW;
        end else if (r_eq && c_lt) begin
            rd_kind_in = RD_COL;
        end else if (r_eq && c_eq) begin
            rd_kind_in = RD_TOTAL;
        end else begin
            rd_kind_in = RD_ZERO;
        end

        pair_re    = col_acc || rd_acc;
        pair_raddr = '0;
        if (col_acc) begin
            pair_raddr = PAIR_AW'(win_target_next) * PAIR_AW'(DIM) + PAIR_AW'(win_query_next);
        end else if (rd_kind_in == RD_PAIR) begin
            pair_raddr = PAIR_AW'(s_row_index) * PAIR_AW'(DIM) + PAIR_AW'(s_col_index);
        end

        marg_re    = col_acc || rd_acc || (state_reg == S_UPD);
        marg_raddr = '0;
        if (state_reg == S_UPD) begin
            marg_raddr = MARG_AW'(DIM) + MARG_AW'(win_query);
        end else if (col_acc) begin
            marg_raddr = MARG_AW'(win_target_next);
        end else if (rd_kind_in == RD_ROW) begin
            marg_raddr = MARG_AW'(s_row_index);
        end else if (rd_kind_in == RD_COL) begin
            marg_raddr = MARG_AW'(DIM) + MARG_AW'(s_col_index);
        end

        pair_we    = 1'b0;
        pair_waddr = PAIR_AW'(win_target) * PAIR_AW'(DIM) + PAIR_AW'(win_query);
        pair_wdata = sat_inc(pair_rdata);
        marg_we    = 1'b0;
        marg_waddr = MARG_AW'(win_target);
        marg_wdata = sat_inc(marg_data);
        case (state_reg)
            S_CLEAR: begin
                pair_we    = 1'b1;
                pair_waddr = clr_reg;
                pair_wdata = '0;
                marg_we    = int'(clr_reg) < MARG_DEPTH;
                marg_waddr = MARG_AW'(clr_reg);
                marg_wdata = '0;
            end
            S_UPD: begin
                pair_we = 1'b1;
                marg_we = 1'b1;
            end
            S_COL: begin
                marg_we    = 1'b1;
                marg_waddr = MARG_AW'(DIM) + MARG_AW'(win_query);
            end
            default: begin
                pair_we = 1'b0;
                marg_we = 1'b0;
            end
        endcase

        case (rd_kind_reg)
            RD_PAIR:  sel_val = pair_rdata;
            RD_ROW:   sel_val = marg_data;
            RD_COL:   sel_val = marg_data;
            RD_TOTAL: sel_val = total_reg;
            default:  sel_val = '0;
        endcase
        sel_ext = EXT_BITS'(sel_val);
    end

    always_comb begin
        state_next    = state_reg;
        rd_kind_next  = rd_kind_reg;
        clr_next      = clr_reg;
        total_next    = total_reg;
        fwd_next      = marg_re && marg_we && (marg_raddr == marg_waddr);
        fwd_data_next = marg_wdata;
        m_valid_next  = m_valid_reg;
        m_count_next  = m_count_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR: begin
                clr_next = clr_reg + PAIR_AW'(1);
                if (clr_reg == PAIR_AW'(PAIR_DEPTH - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_UPD: begin
                total_next = sat_inc(total_reg);
                state_next = S_COL;
            end
            S_RD: begin
                m_valid_next = 1'b1;
                m_count_next = (sel_ext > EXT_BITS'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF
                                                                     : sel_ext[31:0];
                state_next   = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
                if (col_acc && win_hit) begin
                    state_next = S_UPD;
                end else if (rd_acc) begin
                    state_next   = S_RD;
                    rd_kind_next = rd_kind_in;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            clr_reg     <= '0;
            total_reg   <= '0;
            fwd_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            rd_kind_reg  <= rd_kind_next;
            clr_reg      <= clr_next;
            total_reg    <= total_next;
            fwd_reg      <= fwd_next;
            fwd_data_reg <= fwd_data_next;
            m_valid_reg  <= m_valid_next;
            m_count_reg  <= m_count_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_count = m_count_reg;

endmodule

`default_nettype wire

[rtl/core/akph_ram.sv]
// Single-port-write, single-port-read synchronous RAM with registered read data.
`default_nettype none

module akph_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire              aclk,
    input  wire              wr_en,
    input  wire [AW-1:0]     wr_addr,
    input  wire [WIDTH-1:0]  wr_data,
    input  wire              rd_en,
    input  wire [AW-1:0]     rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

[rtl/core/akph_window.sv]
// Sliding base-5 window indices for target and query, with the window length register.
`default_nettype none

module akph_window #(
    parameter int MAX_WINDOW  = 3,
    localparam int DIGIT_BITS = $clog2(akph_pkg::pow5(MAX_WINDOW))
) (
    input  wire                   aclk,
    input  wire                   aresetn,
    input  wire                   cfg_we,
    input  wire [1:0]             cfg_len,
    input  wire                   col_en,
    input  wire                   end_en,
    input  wire [7:0]             target_char,
    input  wire [7:0]             query_char,
    output logic                  hit,
    output logic [DIGIT_BITS-1:0] target_next,
    output logic [DIGIT_BITS-1:0] query_next,
    output logic [DIGIT_BITS-1:0] target,
    output logic [DIGIT_BITS-1:0] query
);

    import akph_pkg::*;

    localparam int NUM_BITS = $clog2(pow5(MAX_WINDOW) * RADIX);
    localparam int KB       = $clog2(MAX_WINDOW + 1);

    logic [1:0]            window_len_reg;
    logic [DIGIT_BITS-1:0] target_reg;
    logic [DIGIT_BITS-1:0] query_reg;
    logic [KB-1:0]         seen_reg;
    logic [KB-1:0]         seen_next;
    logic [KB-1:0]         eff_k;
    logic [NUM_BITS-1:0]   span;
    logic [NUM_BITS-1:0]   tx;
    logic [NUM_BITS-1:0]   qx;

    always_comb begin
        if (window_len_reg == 2'd0) begin
            eff_k = KB'(1);
        end else if (int'(window_len_reg) > MAX_WINDOW) begin
            eff_k = KB'(MAX_WINDOW);
        end else begin
            eff_k = KB'(window_len_reg);
        end
        span = NUM_BITS'(pow5(int'(eff_k)));
        tx = NUM_BITS'(target_reg) * NUM_BITS'(RADIX) + NUM_BITS'(char_code(target_char));
        qx = NUM_BITS'(query_reg) * NUM_BITS'(RADIX) + NUM_BITS'(char_code(query_char));
        for (int i = 0; i < RADIX - 1; i++) begin
            if (tx >= span) begin
                tx = tx - span;
            end
            if (qx >= span) begin
                qx = qx - span;
            end
        end
        target_next = DIGIT_BITS'(tx);
        query_next  = DIGIT_BITS'(qx);
        seen_next   = (seen_reg < eff_k) ? seen_reg + KB'(1) : seen_reg;
        hit         = (seen_next >= eff_k);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_len_reg <= WINDOW_LEN_RESET;
            target_reg     <= '0;
            query_reg      <= '0;
            seen_reg       <= '0;
        end else if (cfg_we) begin
            window_len_reg <= cfg_len;
            target_reg     <= '0;
            query_reg      <= '0;
            seen_reg       <= '0;
        end else if (end_en) begin
            target_reg <= '0;
            query_reg  <= '0;
            seen_reg   <= '0;
        end else if (col_en) begin
            target_reg <= target_next;
            query_reg  <= query_next;
            seen_reg   <= seen_next;
        end
    end

    assign target = target_reg;
    assign query  = query_reg;

endmodule

`default_nettype wire

[rtl/core/akph_checker.sv]
// Port-level assertions for the aligned k-mer pair histogram, bound to the top level.
`default_nettype none

module akph_checker (
    input wire        aclk,
    input wire        aresetn,
    input wire        s_valid,
    input wire        s_ready,
    input wire [1:0]  s_cmd,
    input wire        m_valid,
    input wire        m_ready,
    input wire [31:0] m_count
);

    import akph_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_count))
        else $error("result transaction dropped or changed while stalled");

    a_read_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_cmd == CMD_READ |-> ##2 $rose(m_valid))
        else $error("read transaction did not produce a result after two cycles");

    a_read_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_cmd == CMD_READ |=> !s_ready)
        else $error("input taken while a read is in flight");

    a_no_spurious: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_cmd == CMD_READ, 2))
        else $error("result appeared without a read transaction");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && !s_ready)
        else $error("ports active right after reset");

endmodule

bind aligned_kmer_pair_histogram akph_checker u_akph_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_cmd   (s_cmd),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_count (m_count)
);

`default_nettype wire

[sim/tb_aligned_kmer_pair_histogram.sv]
// Self-checking testbench for the aligned k-mer pair histogram with a tally-based predictor.
`default_nettype none

module tb_aligned_kmer_pair_histogram;
    import akph_pkg::*;

    localparam int          DIM           = 125;
    localparam logic [6:0]  DIM_SEL       = 7'(DIM);
    localparam logic [1:0]  CMD_UNUSED    = 2'd3;
    localparam int          PHASE_ITEMS   = 110;
    localparam int          SETTLE_CYCLES = 16;
    localparam int          CYCLE_LIMIT   = 500000;
    localparam int          MAX_REPORTS   = 10;
    localparam int          HIT_DEPTH     = 48;

    class kmer_pair_tally;
        bit [31:0]   pair_cnt [DIM*DIM];
        bit [31:0]   row_sum [DIM];
        bit [31:0]   col_sum [DIM];
        bit [31:0]   total;
        logic [1:0]  win_reg;
        int unsigned t_idx;
        int unsigned q_idx;
        int unsigned filled;
        bit [31:0]   expected_counts [$];
        int unsigned hit_rows [$];
        int unsigned hit_cols [$];
        int          mismatches;

        function new();
            foreach (pair_cnt[i]) pair_cnt[i] = '0;
            foreach (row_sum[i]) row_sum[i] = '0;
            foreach (col_sum[i]) col_sum[i] = '0;
            total      = '0;
            win_reg    = WINDOW_LEN_RESET;
            t_idx      = 0;
            q_idx      = 0;
            filled     = 0;
            mismatches = 0;
        endfunction

        function bit [2:0] base_code(input logic [7:0] ch);
            case (ch)
                GAP_CHAR: return CODE_GAP;
                "C", "c": return 3'd1;
                "G", "g": return 3'd2;
                "T", "t": return 3'd3;
                default:  return 3'd0;
            endcase
        endfunction

        function bit [31:0] sat_inc(input bit [31:0] v);
            return (v == '1) ? v : v + 1;
        endfunction

        function void write_window(input logic [1:0] len);
            win_reg = len;
            t_idx   = 0;
            q_idx   = 0;
            filled  = 0;
        endfunction

        function int pending();
            return expected_counts.size();
        endfunction

        function void apply_item(input logic [1:0] cmd, input logic [7:0] t_ch, q_ch,
                                 input logic [6:0] row, col);
            int unsigned k;
            int unsigned span;
            bit [31:0]   value;
            case (cmd)
                CMD_COLUMN: begin
                    k = (win_reg == 2'd0) ? 1 : win_reg;
                    span = 1;
                    repeat (k) span = span * RADIX;
                    t_idx = (t_idx * RADIX + base_code(t_ch)) % span;
                    q_idx = (q_idx * RADIX + base_code(q_ch)) % span;
                    if (filled < k) filled++;
                    if (filled >= k) begin
                        pair_cnt[t_idx*DIM + q_idx] = sat_inc(pair_cnt[t_idx*DIM + q_idx]);
                        row_sum[t_idx] = sat_inc(row_sum[t_idx]);
                        col_sum[q_idx] = sat_inc(col_sum[q_idx]);
                        total = sat_inc(total);
                        hit_rows.push_back(t_idx);
                        hit_cols.push_back(q_idx);
                        if (hit_rows.size() > HIT_DEPTH) begin
                            void'(hit_rows.pop_front());
                            void'(hit_cols.pop_front());
                        end
                    end
                end
                CMD_END: begin
                    t_idx  = 0;
                    q_idx  = 0;
                    filled = 0;
                end
                CMD_READ: begin
                    value = '0;
                    if (row < DIM && col < DIM) value = pair_cnt[row*DIM + col];
                    else if (row < DIM && col == DIM) value = row_sum[row];
                    else if (row == DIM && col < DIM) value = col_sum[col];
                    else if (row == DIM && col == DIM) value = total;
                    expected_counts.push_back(value);
                end
                default: begin
                end
            endcase
        endfunction

        function void check_count(input logic [31:0] got);
            bit [31:0] want;
            if (expected_counts.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("unexpected count transaction: got %0d", got);
                mismatches++;
                return;
            end
            want = expected_counts.pop_front();
            if (got !== want) begin
                if (mismatches < MAX_REPORTS)
                    $display("count mismatch: expected %0d got %0d", want, got);
                mismatches++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_window_len;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_cmd;
    logic [7:0]  s_target_char;
    logic [7:0]  s_query_char;
    logic [6:0]  s_row_index;
    logic [6:0]  s_col_index;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_count;

    kmer_pair_tally tally;
    bit             in_steady  = 1'b0;
    bit             out_steady = 1'b0;
    int             items_sent = 0;
    int             cycles     = 0;

    aligned_kmer_pair_histogram dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_window_len (cfg_window_len),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_target_char  (s_target_char),
        .s_query_char   (s_query_char),
        .s_row_index    (s_row_index),
        .s_col_index    (s_col_index),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_count        (m_count)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic int draw_gap(input bit steady);
        return steady ? 0 : $urandom_range(0, 12);
    endfunction

    function automatic logic [7:0] pick_char();
        string bases;
        bases = "ACGTacgt-";
        if ($urandom_range(0, 15) == 0) return 8'($urandom_range(0, 255));
        return bases[$urandom_range(0, 8)];
    endfunction

    task automatic send_item(input logic [1:0] cmd, input logic [7:0] t_ch, q_ch,
                             input logic [6:0] row, col);
        int gap;
        gap = draw_gap(in_steady);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_cmd         <= cmd;
        s_target_char <= t_ch;
        s_query_char  <= q_ch;
        s_row_index   <= row;
        s_col_index   <= col;
        do @(posedge aclk); while (s_ready !== 1'b1);
        tally.apply_item(cmd, t_ch, q_ch, row, col);
        if (cmd != CMD_UNUSED) items_sent++;
    endtask

    task automatic send_probe();
        int         sel;
        int         h;
        logic [6:0] row;
        logic [6:0] col;
        sel = $urandom_range(0, 99);
        row = 7'($urandom_range(0, 127));
        col = 7'($urandom_range(0, 127));
        if (tally.hit_rows.size() != 0 && sel < 80) begin
            h   = $urandom_range(0, tally.hit_rows.size() - 1);
            row = 7'(tally.hit_rows[h]);
            col = 7'(tally.hit_cols[h]);
            if (sel >= 50 && sel < 65) col = DIM_SEL;
            else if (sel >= 65 && sel < 75) row = DIM_SEL;
            else if (sel >= 75) begin
                row = DIM_SEL;
                col = DIM_SEL;
            end
        end
        send_item(CMD_READ, 8'($urandom), 8'($urandom), row, col);
    endtask

    task automatic write_window(input logic [1:0] len);
        cfg_window_len <= len;
        cfg_valid      <= 1'b1;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        tally.write_window(len);
        cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (tally.pending() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin : result_sink
        int stall;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            stall = draw_gap(out_steady);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid === 1'b1 && m_ready === 1'b1));
            tally.check_count(m_count);
        end
    end

    initial begin : stimulus
        logic [1:0] phase_windows [8];
        int         goal;
        int         len;
        tally          = new();
        phase_windows  = '{2'd1, 2'd0, 2'd2, 2'd3, 2'd0, 2'd1, 2'd3, 2'd2};
        aresetn        <= 1'b0;
        cfg_valid      <= 1'b0;
        cfg_window_len <= 2'd0;
        s_valid        <= 1'b0;
        s_cmd          <= CMD_COLUMN;
        s_target_char  <= 8'h00;
        s_query_char   <= 8'h00;
        s_row_index    <= 7'd0;
        s_col_index    <= 7'd0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        send_item(CMD_READ,   8'h00, 8'h00, DIM_SEL, DIM_SEL);
        send_item(CMD_COLUMN, "A",   "T",   7'd0, 7'd0);
        send_item(CMD_COLUMN, "c",   "g",   7'h7F, 7'h7F);
        send_item(CMD_COLUMN, "G",   "-",   7'd0, 7'd0);
        send_item(CMD_COLUMN, "t",   "C",   7'd0, 7'd0);
        send_item(CMD_COLUMN, "-",   "a",   7'd0, 7'd0);
        send_item(CMD_COLUMN, 8'hFF, 8'h00, 7'd0, 7'd0);
        send_item(CMD_COLUMN, "X",   "N",   7'd0, 7'd0);
        send_item(CMD_READ,   8'hFF, 8'hFF, 7'd7, 7'd89);
        send_item(CMD_READ,   8'h00, 8'h00, 7'd7, DIM_SEL);
        send_item(CMD_READ,   8'h00, 8'h00, DIM_SEL, 7'd89);
        send_item(CMD_READ,   8'h00, 8'h00, DIM_SEL, DIM_SEL);
        send_item(CMD_READ,   8'h00, 8'h00, 7'd126, 7'd0);
        send_item(CMD_READ,   8'h00, 8'h00, 7'd0, 7'd127);
        send_item(CMD_READ,   8'h00, 8'h00, 7'd127, 7'd127);
        send_item(CMD_UNUSED, 8'hFF, 8'hFF, 7'h7F, 7'h7F);
        send_item(CMD_END,    8'h00, 8'h00, 7'd0, 7'd0);
        send_item(CMD_COLUMN, "G",   "G",   7'd0, 7'd0);
        send_item(CMD_COLUMN, "G",   "G",   7'd0, 7'd0);
        send_item(CMD_READ,   8'h00, 8'h00, DIM_SEL, DIM_SEL);
        send_item(CMD_COLUMN, "G",   "G",   7'd0, 7'd0);
        send_item(CMD_READ,   8'h00, 8'h00, 7'd62, 7'd62);
        send_item(CMD_READ,   8'h00, 8'h00, 7'd124, 7'd124);
        send_item(CMD_END,    8'h00, 8'h00, 7'd0, 7'd0);

        foreach (phase_windows[p]) begin
            settle();
            write_window(phase_windows[p]);
            in_steady  = ($urandom_range(0, 3) == 0);
            out_steady = ($urandom_range(0, 3) == 0);
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal) begin
                if ($urandom_range(0, 99) < 85) begin
                    len = $urandom_range(1, 12);
                    repeat (len) begin
                        send_item(CMD_COLUMN, pick_char(), pick_char(),
                                  7'($urandom), 7'($urandom));
                        if ($urandom_range(0, 4) == 0) send_probe();
                    end
                    if ($urandom_range(0, 9) != 0)
                        send_item(CMD_END, 8'($urandom), 8'($urandom),
                                  7'($urandom), 7'($urandom));
                    send_probe();
                end else begin
                    case ($urandom_range(0, 2))
                        0: send_item(CMD_UNUSED, 8'($urandom), 8'($urandom),
                                     7'($urandom), 7'($urandom));
                        1: send_item(CMD_READ, 8'($urandom), 8'($urandom),
                                     7'($urandom), 7'($urandom));
                        default: send_item(CMD_COLUMN, 8'($urandom), 8'($urandom),
                                           7'($urandom), 7'($urandom));
                    endcase
                end
            end
        end

        settle();
        if (tally.mismatches == 0 && tally.pending() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
